@@ rtl/lsvg_pkg.sv @@
// Lattice shell vector generator: shared types, constants and tables.
// Used by lsvg_ctrl, lsvg_dp and the top level; no dependencies.
package lsvg_pkg;

    localparam int MAX_EXTENT = 15;
    localparam int EXT_W      = 4;
    localparam int COMP_W     = 21;
    localparam int COORD_W    = 27;
    localparam int SQ_W       = 52;
    localparam int CNT_W      = 15;
    localparam int PH_W       = 4;
    localparam int CFG_W      = 63;
    localparam int NUM_CFG    = 4;
    localparam int SIGN_W     = 3;

    localparam logic [PH_W-1:0] PH_DONE = 4'd8;
    localparam logic [1:0]      NO_AXIS = 2'd3;

    typedef enum logic [1:0] {
        CFG_BASIS_A,
        CFG_BASIS_B,
        CFG_BASIS_C,
        CFG_OFFSET
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ0,
        S_SQ1,
        S_SQ2,
        S_ADV,
        S_ENTER,
        S_SETTLE,
        S_FIN
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_CLEAR,
        OP_ORIGIN,
        OP_SUM,
        OP_SQ0,
        OP_SQ1,
        OP_SQ2,
        OP_ADV,
        OP_STEP,
        OP_INIT,
        OP_PHASE_INC,
        OP_LOAD
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic start_bad;
        logic remain_zero;
        logic phase_done;
        logic phase_zero;
        logic phase_empty;
        logic pos_valid;
        logic step_wrap;
        logic sign_wrap;
    } t_status;

    function automatic logic [EXT_W-1:0] sat_ext(input logic [EXT_W-1:0] v);
        logic [EXT_W-1:0] lim;
        lim = EXT_W'(MAX_EXTENT);
        return (v > lim) ? lim : v;
    endfunction

    // active axes per phase, innermost loop in bits 1:0
    function automatic logic [5:0] loop_axes(input logic [PH_W-1:0] ph);
        logic [5:0] r;
        unique case (ph)
            4'd1:    r = {NO_AXIS, NO_AXIS, 2'd0};
            4'd2:    r = {NO_AXIS, NO_AXIS, 2'd1};
            4'd3:    r = {NO_AXIS, NO_AXIS, 2'd2};
            4'd4:    r = {NO_AXIS, 2'd0, 2'd1};
            4'd5:    r = {NO_AXIS, 2'd1, 2'd2};
            4'd6:    r = {NO_AXIS, 2'd0, 2'd2};
            4'd7:    r = {2'd2, 2'd0, 2'd1};
            default: r = {NO_AXIS, NO_AXIS, NO_AXIS};
        endcase
        return r;
    endfunction

    function automatic logic [3:0] sign_count(input logic [PH_W-1:0] ph);
        logic [3:0] r;
        unique case (ph)
            4'd1, 4'd2, 4'd3: r = 4'd2;
            4'd4, 4'd5, 4'd6: r = 4'd4;
            4'd7:             r = 4'd8;
            default:          r = 4'd1;
        endcase
        return r;
    endfunction

    // bit0 negates i*A, bit1 j*B, bit2 k*C
    function automatic logic [2:0] neg_mask(input logic [PH_W-1:0] ph,
                                            input logic [SIGN_W-1:0] st);
        logic [23:0] l;
        unique case (ph)
            4'd1:    l = {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd0};
            4'd2:    l = {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd0};
            4'd3:    l = {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd0};
            4'd4:    l = {3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd3, 3'd1, 3'd0};
            4'd5:    l = {3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd6, 3'd4, 3'd0};
            4'd6:    l = {3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd5, 3'd4, 3'd0};
            4'd7:    l = {3'd7, 3'd5, 3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd0};
            default: l = '0;
        endcase
        return l[3*st +: 3];
    endfunction

endpackage

@@ rtl/lsvg_ctrl.sv @@
// Lattice shell vector generator: sequencing state machine.
// Depends on lsvg_pkg; drives lsvg_dp through t_cmd, reads t_status.
module lsvg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_command,
    input  logic             i_out_ready,
    input  lsvg_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output lsvg_pkg::t_cmd   o_cmd
);

    lsvg_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsvg_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = lsvg_pkg::OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            lsvg_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_valid) begin
                    if (!i_command) begin
                        o_cmd.op = lsvg_pkg::OP_LATCH;
                        n_state  = i_status.start_bad ? lsvg_pkg::S_FIN : lsvg_pkg::S_ENTER;
                    end else if (i_status.remain_zero || i_status.phase_done) begin
                        o_cmd.op = lsvg_pkg::OP_CLEAR;
                        n_state  = lsvg_pkg::S_FIN;
                    end else if (i_status.phase_zero) begin
                        o_cmd.op = lsvg_pkg::OP_ORIGIN;
                        n_state  = lsvg_pkg::S_ADV;
                    end else begin
                        o_cmd.op = lsvg_pkg::OP_SUM;
                        n_state  = lsvg_pkg::S_SQ0;
                    end
                end
            end
            lsvg_pkg::S_SQ0: begin
                o_cmd.op = lsvg_pkg::OP_SQ0;
                n_state  = lsvg_pkg::S_SQ1;
            end
            lsvg_pkg::S_SQ1: begin
                o_cmd.op = lsvg_pkg::OP_SQ1;
                n_state  = lsvg_pkg::S_SQ2;
            end
            lsvg_pkg::S_SQ2: begin
                o_cmd.op = lsvg_pkg::OP_SQ2;
                n_state  = lsvg_pkg::S_ADV;
            end
            lsvg_pkg::S_ADV: begin
                o_cmd.op = lsvg_pkg::OP_ADV;
                if (!i_status.sign_wrap) begin
                    n_state = lsvg_pkg::S_FIN;
                end else if (i_status.step_wrap) begin
                    n_state = lsvg_pkg::S_ENTER;
                end else begin
                    n_state = lsvg_pkg::S_SETTLE;
                end
            end
            lsvg_pkg::S_ENTER: begin
                if (i_status.phase_done) begin
                    n_state = lsvg_pkg::S_FIN;
                end else if (i_status.phase_empty) begin
                    o_cmd.op = lsvg_pkg::OP_PHASE_INC;
                end else begin
                    o_cmd.op = lsvg_pkg::OP_INIT;
                    n_state  = lsvg_pkg::S_SETTLE;
                end
            end
            lsvg_pkg::S_SETTLE: begin
                if (i_status.phase_done || i_status.pos_valid) begin
                    n_state = lsvg_pkg::S_FIN;
                end else begin
                    o_cmd.op = lsvg_pkg::OP_STEP;
                    if (i_status.step_wrap) begin
                        n_state = lsvg_pkg::S_ENTER;
                    end
                end
            end
            lsvg_pkg::S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op = lsvg_pkg::OP_LOAD;
                    n_state  = lsvg_pkg::S_IDLE;
                end
            end
            default: n_state = lsvg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.op == lsvg_pkg::OP_LOAD) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_sum_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == lsvg_pkg::OP_SUM) |->
        (!i_status.remain_zero && !i_status.phase_done && !i_status.phase_zero))
        else $error("point computed with no point pending");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lsvg_pkg::S_FIN && (!r_out_valid || i_out_ready)) |=> r_out_valid)
        else $error("finished item not presented");

    a_bad_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_valid && !i_command && i_status.start_bad) |=>
        (r_state == lsvg_pkg::S_FIN))
        else $error("bad start did not finish at once");

endmodule

@@ rtl/lsvg_dp.sv @@
// Lattice shell vector generator: datapath with configuration, walk state,
// coordinate sum, shared squarer and result registers. Depends on lsvg_pkg.
module lsvg_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lsvg_pkg::t_cmd                        i_cmd,
    output lsvg_pkg::t_status                     o_status,
    input  logic                                  i_cfg_we,
    input  lsvg_pkg::t_cfg_idx                    i_cfg_index,
    input  logic [lsvg_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic [lsvg_pkg::EXT_W-1:0]            i_old_x,
    input  logic [lsvg_pkg::EXT_W-1:0]            i_old_y,
    input  logic [lsvg_pkg::EXT_W-1:0]            i_old_z,
    input  logic [lsvg_pkg::EXT_W-1:0]            i_new_x,
    input  logic [lsvg_pkg::EXT_W-1:0]            i_new_y,
    input  logic [lsvg_pkg::EXT_W-1:0]            i_new_z,
    output logic signed [lsvg_pkg::COORD_W-1:0]   o_coord_x,
    output logic signed [lsvg_pkg::COORD_W-1:0]   o_coord_y,
    output logic signed [lsvg_pkg::COORD_W-1:0]   o_coord_z,
    output logic [lsvg_pkg::SQ_W-1:0]             o_square_x,
    output logic [lsvg_pkg::SQ_W-1:0]             o_square_y,
    output logic [lsvg_pkg::SQ_W-1:0]             o_square_z,
    output logic [lsvg_pkg::CNT_W-1:0]            o_point_count,
    output logic                                  o_point_valid,
    output logic                                  o_last_point
);

    logic [lsvg_pkg::CFG_W-1:0]  r_cfg [lsvg_pkg::NUM_CFG];
    logic [lsvg_pkg::EXT_W-1:0]  r_old [3];
    logic [lsvg_pkg::EXT_W-1:0]  r_new [3];
    logic [lsvg_pkg::EXT_W-1:0]  r_idx [3];
    logic [lsvg_pkg::PH_W-1:0]   r_phase;
    logic [lsvg_pkg::SIGN_W-1:0] r_sign;
    logic [lsvg_pkg::CNT_W-1:0]  r_remain;

    logic signed [lsvg_pkg::COORD_W-1:0] r_w_coord [3];
    logic [lsvg_pkg::SQ_W-1:0]           r_w_sq [3];
    logic [lsvg_pkg::CNT_W-1:0]          r_w_count;
    logic                                r_w_pv, r_w_last;

    logic signed [lsvg_pkg::COORD_W-1:0] r_o_coord [3];
    logic [lsvg_pkg::SQ_W-1:0]           r_o_sq [3];
    logic [lsvg_pkg::CNT_W-1:0]          r_o_count;
    logic                                r_o_pv, r_o_last;

    // start decode
    logic [lsvg_pkg::EXT_W-1:0] e_old [3];
    logic [lsvg_pkg::EXT_W-1:0] e_new [3];
    logic                       bad, zero_old;
    logic [lsvg_pkg::CNT_W-1:0] outer, inner, cnt;

    always_comb begin
        e_old[0] = lsvg_pkg::sat_ext(i_old_x);
        e_old[1] = lsvg_pkg::sat_ext(i_old_y);
        e_old[2] = lsvg_pkg::sat_ext(i_old_z);
        e_new[0] = lsvg_pkg::sat_ext(i_new_x);
        e_new[1] = lsvg_pkg::sat_ext(i_new_y);
        e_new[2] = lsvg_pkg::sat_ext(i_new_z);
        bad = (e_old[0] > e_new[0]) || (e_old[1] > e_new[1]) || (e_old[2] > e_new[2]);
        zero_old = (e_old[0] == '0) && (e_old[1] == '0) && (e_old[2] == '0);
        outer = lsvg_pkg::CNT_W'({e_new[0], 1'b1}) * lsvg_pkg::CNT_W'({e_new[1], 1'b1})
              * lsvg_pkg::CNT_W'({e_new[2], 1'b1});
        inner = lsvg_pkg::CNT_W'({e_old[0], 1'b1}) * lsvg_pkg::CNT_W'({e_old[1], 1'b1})
              * lsvg_pkg::CNT_W'({e_old[2], 1'b1});
        cnt = bad ? '0 : (outer - inner + lsvg_pkg::CNT_W'(zero_old));
    end

    // position walk
    logic [5:0]                 axes;
    logic [lsvg_pkg::EXT_W-1:0] st_idx [3];
    logic [lsvg_pkg::EXT_W-1:0] init_idx [3];
    logic                       st_wrap, st_fin, empty;
    logic [1:0]                 ax;
    logic [3:0]                 sign_nx;
    logic                       sign_wrap;

    always_comb begin
        axes    = lsvg_pkg::loop_axes(r_phase);
        st_idx  = r_idx;
        st_wrap = 1'b1;
        st_fin  = 1'b0;
        empty   = 1'b0;
        for (int n = 0; n < 3; n++) begin
            init_idx[n] = '0;
        end
        for (int n = 0; n < 3; n++) begin
            ax = axes[2*n +: 2];
            if (ax != lsvg_pkg::NO_AXIS) begin
                init_idx[ax] = lsvg_pkg::EXT_W'(1);
                if (r_new[ax] == '0) begin
                    empty = 1'b1;
                end
            end
            if (!st_fin) begin
                if (ax == lsvg_pkg::NO_AXIS) begin
                    st_fin = 1'b1;
                end else if (r_idx[ax] < r_new[ax]) begin
                    st_idx[ax] = r_idx[ax] + lsvg_pkg::EXT_W'(1);
                    st_wrap    = 1'b0;
                    st_fin     = 1'b1;
                end else begin
                    st_idx[ax] = lsvg_pkg::EXT_W'(1);
                end
            end
        end
        sign_nx   = {1'b0, r_sign} + 4'd1;
        sign_wrap = (sign_nx >= lsvg_pkg::sign_count(r_phase));
    end

    always_comb begin
        o_status.start_bad   = bad;
        o_status.remain_zero = (r_remain == '0);
        o_status.phase_done  = (r_phase >= lsvg_pkg::PH_DONE);
        o_status.phase_zero  = (r_phase == '0);
        o_status.phase_empty = empty;
        o_status.pos_valid   = (r_phase == '0) || (r_idx[0] > r_old[0])
                             || (r_idx[1] > r_old[1]) || (r_idx[2] > r_old[2]);
        o_status.step_wrap   = st_wrap;
        o_status.sign_wrap   = sign_wrap;
    end

    // coordinate sum
    logic [2:0]                          msk;
    logic signed [lsvg_pkg::EXT_W:0]     s_idx [3];
    logic signed [lsvg_pkg::COMP_W-1:0]  bc;
    logic signed [lsvg_pkg::COORD_W:0]   acc;
    logic signed [lsvg_pkg::COORD_W-1:0] sum_c [3];

    always_comb begin
        msk = lsvg_pkg::neg_mask(r_phase, r_sign);
        for (int t = 0; t < 3; t++) begin
            s_idx[t] = msk[t] ? -$signed({1'b0, r_idx[t]}) : $signed({1'b0, r_idx[t]});
        end
        for (int n = 0; n < 3; n++) begin
            bc  = $signed(r_cfg[lsvg_pkg::CFG_OFFSET][lsvg_pkg::COMP_W*n +: lsvg_pkg::COMP_W]);
            acc = (lsvg_pkg::COORD_W+1)'(bc);
            for (int t = 0; t < 3; t++) begin
                bc  = $signed(r_cfg[t][lsvg_pkg::COMP_W*n +: lsvg_pkg::COMP_W]);
                acc = acc + (lsvg_pkg::COORD_W+1)'(s_idx[t]) * (lsvg_pkg::COORD_W+1)'(bc);
            end
            sum_c[n] = acc[lsvg_pkg::COORD_W-1:0];
        end
    end

    // shared squarer
    logic [1:0]                          sq_sel;
    logic signed [lsvg_pkg::COORD_W-1:0] sq_in;
    logic [lsvg_pkg::COORD_W-1:0]        sq_mag;
    logic [2*lsvg_pkg::COORD_W-1:0]      sq_full;

    always_comb begin
        unique case (i_cmd.op)
            lsvg_pkg::OP_SQ1: sq_sel = 2'd1;
            lsvg_pkg::OP_SQ2: sq_sel = 2'd2;
            default:          sq_sel = 2'd0;
        endcase
        sq_in   = r_w_coord[sq_sel];
        sq_mag  = sq_in[lsvg_pkg::COORD_W-1] ? lsvg_pkg::COORD_W'(-sq_in)
                                             : lsvg_pkg::COORD_W'(sq_in);
        sq_full = sq_mag * sq_mag;
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < lsvg_pkg::NUM_CFG; r++) begin
                r_cfg[r] <= '0;
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= lsvg_pkg::PH_DONE;
            r_sign   <= '0;
            r_remain <= '0;
            for (int t = 0; t < 3; t++) begin
                r_idx[t] <= '0;
                r_old[t] <= '0;
                r_new[t] <= '0;
            end
        end else begin
            unique case (i_cmd.op)
                lsvg_pkg::OP_LATCH: begin
                    r_old    <= e_old;
                    r_new    <= e_new;
                    r_remain <= cnt;
                    r_sign   <= '0;
                    for (int t = 0; t < 3; t++) begin
                        r_idx[t] <= '0;
                    end
                    if (bad) begin
                        r_phase <= lsvg_pkg::PH_DONE;
                    end else begin
                        r_phase <= zero_old ? lsvg_pkg::PH_W'(0) : lsvg_pkg::PH_W'(1);
                    end
                end
                lsvg_pkg::OP_ORIGIN, lsvg_pkg::OP_SUM: begin
                    r_remain <= r_remain - lsvg_pkg::CNT_W'(1);
                end
                lsvg_pkg::OP_ADV: begin
                    if (sign_wrap) begin
                        r_sign <= '0;
                        r_idx  <= st_idx;
                        if (st_wrap) begin
                            r_phase <= r_phase + lsvg_pkg::PH_W'(1);
                        end
                    end else begin
                        r_sign <= sign_nx[lsvg_pkg::SIGN_W-1:0];
                    end
                end
                lsvg_pkg::OP_STEP: begin
                    r_idx <= st_idx;
                    if (st_wrap) begin
                        r_phase <= r_phase + lsvg_pkg::PH_W'(1);
                    end
                end
                lsvg_pkg::OP_INIT: begin
                    r_idx  <= init_idx;
                    r_sign <= '0;
                end
                lsvg_pkg::OP_PHASE_INC: begin
                    r_phase <= r_phase + lsvg_pkg::PH_W'(1);
                end
                default: ;
            endcase
        end
    end

    // working result and output registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            lsvg_pkg::OP_LATCH, lsvg_pkg::OP_CLEAR: begin
                for (int n = 0; n < 3; n++) begin
                    r_w_coord[n] <= '0;
                    r_w_sq[n]    <= '0;
                end
                r_w_count <= (i_cmd.op == lsvg_pkg::OP_LATCH) ? cnt : '0;
                r_w_pv    <= 1'b0;
                r_w_last  <= 1'b0;
            end
            lsvg_pkg::OP_ORIGIN, lsvg_pkg::OP_SUM: begin
                for (int n = 0; n < 3; n++) begin
                    r_w_coord[n] <= (i_cmd.op == lsvg_pkg::OP_SUM) ? sum_c[n] : '0;
                    r_w_sq[n]    <= '0;
                end
                r_w_count <= '0;
                r_w_pv    <= 1'b1;
                r_w_last  <= (r_remain == lsvg_pkg::CNT_W'(1));
            end
            lsvg_pkg::OP_SQ0, lsvg_pkg::OP_SQ1, lsvg_pkg::OP_SQ2: begin
                r_w_sq[sq_sel] <= sq_full[lsvg_pkg::SQ_W-1:0];
            end
            lsvg_pkg::OP_LOAD: begin
                r_o_coord <= r_w_coord;
                r_o_sq    <= r_w_sq;
                r_o_count <= r_w_count;
                r_o_pv    <= r_w_pv;
                r_o_last  <= r_w_last;
            end
            default: ;
        endcase
    end

    assign o_coord_x     = r_o_coord[0];
    assign o_coord_y     = r_o_coord[1];
    assign o_coord_z     = r_o_coord[2];
    assign o_square_x    = r_o_sq[0];
    assign o_square_y    = r_o_sq[1];
    assign o_square_z    = r_o_sq[2];
    assign o_point_count = r_o_count;
    assign o_point_valid = r_o_pv;
    assign o_last_point  = r_o_last;

endmodule

@@ rtl/lattice_shell_vector_generator_top.sv @@
// Lattice shell vector generator, top level.
// Depends on lsvg_pkg, lsvg_ctrl and lsvg_dp.
//
//   channel  handshake                 payload
//   in       i_valid / o_ready         i_command, i_old_*, i_new_*
//   out      o_valid / i_ready         o_coord_*, o_square_*, o_point_count, flags
//   cfg      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Start item: latch, enter, settle, hand-over; an old extent above its new one skips
// to hand-over. Next item: sum, three squarings on one shared 27x27 multiplier,
// advance, hand-over; a sign wrap adds a settle, a phase end an enter and a settle.
// Origin skips sum and squarings; a next with nothing left clears and hands over.
// Each empty phase or skipped position adds a step. Synchronous active-low reset;
// cfg always ready. Hand-over waits while the output register holds an untaken item.
module lattice_shell_vector_generator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_command,
    input  logic [lsvg_pkg::EXT_W-1:0]          i_old_x,
    input  logic [lsvg_pkg::EXT_W-1:0]          i_old_y,
    input  logic [lsvg_pkg::EXT_W-1:0]          i_old_z,
    input  logic [lsvg_pkg::EXT_W-1:0]          i_new_x,
    input  logic [lsvg_pkg::EXT_W-1:0]          i_new_y,
    input  logic [lsvg_pkg::EXT_W-1:0]          i_new_z,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [lsvg_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [lsvg_pkg::COORD_W-1:0] o_coord_x,
    output logic signed [lsvg_pkg::COORD_W-1:0] o_coord_y,
    output logic signed [lsvg_pkg::COORD_W-1:0] o_coord_z,
    output logic [lsvg_pkg::SQ_W-1:0]           o_square_x,
    output logic [lsvg_pkg::SQ_W-1:0]           o_square_y,
    output logic [lsvg_pkg::SQ_W-1:0]           o_square_z,
    output logic [lsvg_pkg::CNT_W-1:0]          o_point_count,
    output logic                                o_point_valid,
    output logic                                o_last_point
);

    lsvg_pkg::t_cmd    cmd;
    lsvg_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    lsvg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_command   (i_command),
        .i_out_ready (i_ready),
        .i_status    (status),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    lsvg_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (lsvg_pkg::t_cfg_idx'(i_cfg_index)),
        .i_cfg_data    (i_cfg_data),
        .i_old_x       (i_old_x),
        .i_old_y       (i_old_y),
        .i_old_z       (i_old_z),
        .i_new_x       (i_new_x),
        .i_new_y       (i_new_y),
        .i_new_z       (i_new_z),
        .o_coord_x     (o_coord_x),
        .o_coord_y     (o_coord_y),
        .o_coord_z     (o_coord_z),
        .o_square_x    (o_square_x),
        .o_square_y    (o_square_y),
        .o_square_z    (o_square_z),
        .o_point_count (o_point_count),
        .o_point_valid (o_point_valid),
        .o_last_point  (o_last_point)
    );

endmodule
